[rtl/phlm_pkg.sv]
`timescale 1ns / 1ps
// phlm_pkg: shared types and constants for the peak hold level meter
// no dependencies
package phlm_pkg;

  localparam int LEVEL_BITS_DEF = 16;
  localparam int MW             = 33;   // shared multiplier operand width
  localparam int CFG_IDX_W      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HUE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX   = 3'd6;

  localparam logic [14:0] PHASE_RATE = 15'd31291;
  localparam logic [30:0] INV_E_Q32  = 31'd1580030168;
  localparam logic [15:0] PULSE_BASE = 16'd3277;
  localparam logic [12:0] PULSE_SPAN = 13'd4588;
  localparam logic [8:0]  AMBER_HUE  = 9'd38;
  localparam logic [8:0]  HUE_WRAP   = 9'd360;
  localparam logic [32:0] X_LIMIT    = 33'(24) << 16;
  localparam int          DIV_STEPS  = 33;
  localparam int          TAYLOR_K   = 9;

  typedef enum logic [4:0] {
    S_IDLE, S_PHASE, S_DECIDE, S_XDIV, S_TMUL, S_TDIV0, S_TDIV, S_EMUL, S_EUSE,
    S_ALPHA, S_PEAK, S_SHOW, S_LIT, S_LIT2, S_VAL,
    S_S1, S_S2, S_S3, S_S4, S_S5, S_S6
  } state_e;

endpackage

[rtl/phlm_if.sv]
`timescale 1ns / 1ps
// phlm channel interfaces: tick requests, result requests and register writes
// depends on phlm_pkg
interface phlm_in_if import phlm_pkg::*; #(parameter int LB = LEVEL_BITS_DEF);
  logic          valid;
  logic          ready;
  logic [15:0]   delta_time;
  logic [LB-1:0] level;
  logic          live;
  modport source (output valid, delta_time, level, live, input ready);
  modport sink   (input valid, delta_time, level, live, output ready);
endinterface

interface phlm_out_if import phlm_pkg::*; #(parameter int LB = LEVEL_BITS_DEF);
  logic          valid;
  logic          ready;
  logic [8:0]    out_hue;
  logic [15:0]   out_sat;
  logic [15:0]   out_val;
  logic [LB-1:0] peak_level;
  modport source (output valid, out_hue, out_sat, out_val, peak_level, input ready);
  modport sink   (input valid, out_hue, out_sat, out_val, peak_level, output ready);
endinterface

interface phlm_cfg_if import phlm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/peak_hold_level_meter.sv]
`timescale 1ns / 1ps
// peak_hold_level_meter: peak hold meter with exponential decay and idle pulse
// depends on phlm_pkg and phlm_if
// the peak follows the level directly, or decays via the 33-step bit-serial divider
//   run ten times, then up to 23 exp steps; the idle pulse takes extra multiply steps
// throughput: one request at a time; the next is taken once the result is registered
// a finished result waits in the output register while the next request is worked on
// reset: async active low, clears peak, phase, control and loads register defaults
module peak_hold_level_meter import phlm_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  phlm_in_if.sink    in_s,
  phlm_out_if.source out_s,
  phlm_cfg_if.sink   cfg_s
);

  localparam int LB = LEVEL_BITS;

  // configuration registers
  logic [8:0]  hue_q;
  logic [15:0] sat_q, val_q, gain_q, floor_q, decay_q, mix_q;

  // sequencer and working registers
  state_e        state_q, state_d;
  logic [15:0]   dt_q, dt_d;
  logic [LB-1:0] lvl_q, lvl_d;
  logic          live_q, live_d;
  logic [15:0]   phase_q, phase_d;
  logic [LB-1:0] peak_q, peak_d;
  logic [32:0]   term_q, term_d, sum_q, sum_d;
  logic [31:0]   f_q, f_d;
  logic [4:0]    n_q, n_d;
  logic [3:0]    k_q, k_d;
  logic [16:0]   u_q, u_d, u2_q, u2_d, t_q, t_d;
  logic          quad_q, quad_d;

  // shared multiplier
  logic [MW-1:0]   mul_a, mul_b;
  logic            mul_en;
  logic [2*MW-1:0] prod_q;

  // shared bit-serial divider
  logic [16:0] div_rem_q, div_rem_d;
  logic [32:0] div_quo_q, div_quo_d;
  logic [15:0] div_den_q, div_den_d;
  logic [5:0]  div_cnt_q, div_cnt_d;
  logic [16:0] rem_sh;
  logic        rem_ge;

  // output register
  logic          ov_q, ov_d;
  logic [8:0]    ohue_q, ohue_d;
  logic [15:0]   osat_q, osat_d, oval_q, oval_d;
  logic [LB-1:0] opeak_q, opeak_d;

  // combinational helpers
  logic          can_load;
  logic [33:0]   alpha_full;
  logic [16:0]   alpha;
  logic [LB-1:0] shown;
  logic [18:0]   lit_sum;
  logic [16:0]   lit;
  logic [16:0]   vprod;
  logic [14:0]   r_fold;
  logic [16:0]   s_cap;
  logic [16:0]   breath;
  logic [LB-1:0] diff;

  assign in_s.ready       = (state_q == S_IDLE);
  assign cfg_s.ready      = 1'b1;
  assign out_s.valid      = ov_q;
  assign out_s.out_hue    = ohue_q;
  assign out_s.out_sat    = osat_q;
  assign out_s.out_val    = oval_q;
  assign out_s.peak_level = opeak_q;

  // result register is free when empty or being taken this cycle
  assign can_load = !ov_q || out_s.ready;

  assign rem_sh = {div_rem_q[15:0], div_quo_q[32]};
  assign rem_ge = (rem_sh >= {1'b0, div_den_q});

  assign alpha_full = 34'(35'h1_0000_8000 - 35'(sum_q));
  assign alpha      = (alpha_full[33:16] > 18'd65536) ? 17'd65536 : alpha_full[32:16];
  assign diff       = peak_q - lvl_q;
  assign shown      = (lvl_q > prod_q[LB+15:16]) ? lvl_q : prod_q[LB+15:16];
  assign lit_sum    = 19'(floor_q) + 19'(prod_q[LB+15:LB-2]);
  assign lit        = (lit_sum > 19'd65536) ? 17'd65536 : lit_sum[16:0];
  assign vprod      = prod_q[32:16];
  assign r_fold     = phase_q[14] ? 15'(15'd16384 - 15'(phase_q[13:0])) : 15'(phase_q[13:0]);
  assign s_cap      = (prod_q[33:16] > 18'd65536) ? 17'd65536 : prod_q[32:16];
  assign breath     = quad_q ? 17'(17'd32768 - 17'(s_cap[16:1]))
                             : 17'(17'd32768 + 17'(s_cap[16:1]));

  always_comb begin
    state_d   = state_q;
    dt_d      = dt_q;
    lvl_d     = lvl_q;
    live_d    = live_q;
    phase_d   = phase_q;
    peak_d    = peak_q;
    term_d    = term_q;
    sum_d     = sum_q;
    f_d       = f_q;
    n_d       = n_q;
    k_d       = k_q;
    u_d       = u_q;
    u2_d      = u2_q;
    t_d       = t_q;
    quad_d    = quad_q;
    mul_a     = '0;
    mul_b     = '0;
    mul_en    = 1'b0;
    div_rem_d = div_rem_q;
    div_quo_d = div_quo_q;
    div_den_d = div_den_q;
    div_cnt_d = div_cnt_q;
    ov_d      = ov_q && !out_s.ready;
    ohue_d    = ohue_q;
    osat_d    = osat_q;
    oval_d    = oval_q;
    opeak_d   = opeak_q;

    // one restoring divide step per cycle while a division runs
    if (div_cnt_q != '0) begin
      div_rem_d = rem_ge ? 17'(rem_sh - {1'b0, div_den_q}) : rem_sh;
      div_quo_d = {div_quo_q[31:0], rem_ge};
      div_cnt_d = div_cnt_q - 6'd1;
    end

    case (state_q)
      S_IDLE: begin
        if (in_s.valid) begin
          dt_d    = in_s.delta_time;
          lvl_d   = in_s.level;
          live_d  = in_s.live;
          state_d = S_PHASE;
        end
      end
      S_PHASE: begin
        mul_a   = MW'(dt_q);
        mul_b   = MW'(PHASE_RATE);
        mul_en  = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        // phase runs on every tick, rounded
        phase_d = 16'(phase_q + 16'(33'(prod_q[32:0]) + 33'd32768 >> 16));
        if (lvl_q >= peak_q || decay_q == '0 || dt_q == '0) begin
          peak_d  = lvl_q;
          state_d = S_SHOW;
        end else begin
          div_rem_d = '0;
          div_quo_d = 33'(dt_q) << 14;
          div_den_d = decay_q;
          div_cnt_d = 6'(DIV_STEPS);
          state_d   = S_XDIV;
        end
      end
      S_XDIV: begin
        if (div_cnt_q == '0) begin
          if (div_quo_q >= X_LIMIT) begin
            sum_d   = '0;
            state_d = S_ALPHA;
          end else begin
            n_d     = div_quo_q[20:16];
            f_d     = {div_quo_q[15:0], 16'h0000};
            term_d  = 33'h1_0000_0000;
            sum_d   = 33'h1_0000_0000;
            k_d     = 4'd1;
            state_d = S_TMUL;
          end
        end
      end
      S_TMUL: begin
        mul_a   = term_q;
        mul_b   = MW'(f_q);
        mul_en  = 1'b1;
        state_d = S_TDIV0;
      end
      S_TDIV0: begin
        div_rem_d = '0;
        div_quo_d = prod_q[64:32];
        div_den_d = 16'(k_q);
        div_cnt_d = 6'(DIV_STEPS);
        state_d   = S_TDIV;
      end
      S_TDIV: begin
        if (div_cnt_q == '0) begin
          term_d = div_quo_q;
          // alternating taylor series of exp(-f)
          sum_d  = k_q[0] ? 33'(sum_q - div_quo_q) : 33'(sum_q + div_quo_q);
          k_d    = k_q + 4'd1;
          state_d = (k_q == 4'(TAYLOR_K)) ? S_EMUL : S_TMUL;
        end
      end
      S_EMUL: begin
        if (n_q == '0) begin
          state_d = S_ALPHA;
        end else begin
          mul_a   = sum_q;
          mul_b   = MW'(INV_E_Q32);
          mul_en  = 1'b1;
          n_d     = n_q - 5'd1;
          state_d = S_EUSE;
        end
      end
      S_EUSE: begin
        sum_d   = prod_q[64:32];
        state_d = S_EMUL;
      end
      S_ALPHA: begin
        mul_a   = MW'(diff);
        mul_b   = MW'(alpha);
        mul_en  = 1'b1;
        state_d = S_PEAK;
      end
      S_PEAK: begin
        peak_d  = peak_q - LB'((prod_q[LB+17:0] + (LB+18)'(32768)) >> 16);
        state_d = S_SHOW;
      end
      S_SHOW: begin
        if (live_q) begin
          mul_a   = MW'(peak_q);
          mul_b   = MW'(mix_q);
          state_d = S_LIT;
        end else begin
          quad_d  = phase_q[15];
          u_d     = {r_fold, 2'b00};
          mul_a   = MW'({r_fold, 2'b00});
          mul_b   = MW'({r_fold, 2'b00});
          state_d = S_S1;
        end
        mul_en = 1'b1;
      end
      S_LIT: begin
        mul_a   = MW'(shown);
        mul_b   = MW'(gain_q);
        mul_en  = 1'b1;
        state_d = S_LIT2;
      end
      S_LIT2: begin
        mul_a   = MW'(val_q);
        mul_b   = MW'(lit);
        mul_en  = 1'b1;
        state_d = S_VAL;
      end
      S_VAL: begin
        if (can_load) begin
          ov_d    = 1'b1;
          ohue_d  = (hue_q >= HUE_WRAP) ? 9'(hue_q - HUE_WRAP) : hue_q;
          osat_d  = sat_q;
          oval_d  = vprod[16] ? 16'hFFFF : vprod[15:0];
          opeak_d = peak_q;
          state_d = S_IDLE;
        end
      end
      S_S1: begin
        u2_d    = prod_q[32:16];
        mul_a   = MW'(prod_q[32:16]);
        mul_b   = MW'(9'd307);
        mul_en  = 1'b1;
        state_d = S_S2;
      end
      S_S2: begin
        t_d     = 17'(18'd5223 - prod_q[33:16]);
        mul_a   = MW'(u2_q);
        mul_b   = MW'(17'(18'd5223 - prod_q[33:16]));
        mul_en  = 1'b1;
        state_d = S_S3;
      end
      S_S3: begin
        t_d     = 17'(18'd42334 - prod_q[33:16]);
        mul_a   = MW'(u2_q);
        mul_b   = MW'(17'(18'd42334 - prod_q[33:16]));
        mul_en  = 1'b1;
        state_d = S_S4;
      end
      S_S4: begin
        t_d     = 17'(18'd102944 - prod_q[33:16]);
        mul_a   = MW'(u_q);
        mul_b   = MW'(17'(18'd102944 - prod_q[33:16]));
        mul_en  = 1'b1;
        state_d = S_S5;
      end
      S_S5: begin
        mul_a   = MW'(PULSE_SPAN);
        mul_b   = MW'(breath);
        mul_en  = 1'b1;
        state_d = S_S6;
      end
      S_S6: begin
        if (can_load) begin
          ov_d    = 1'b1;
          ohue_d  = AMBER_HUE;
          osat_d  = 16'hFFFF;
          oval_d  = 16'(PULSE_BASE + 16'((prod_q[31:0] + 32'd32768) >> 16));
          opeak_d = peak_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= '0;
      peak_q    <= '0;
      ov_q      <= 1'b0;
      div_cnt_q <= '0;
      hue_q     <= '0;
      sat_q     <= '0;
      val_q     <= 16'hFFFF;
      gain_q    <= 16'd16384;
      floor_q   <= '0;
      decay_q   <= '0;
      mix_q     <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      peak_q    <= peak_d;
      ov_q      <= ov_d;
      div_cnt_q <= div_cnt_d;
      if (cfg_s.valid) begin
        case (cfg_s.index)
          CFG_HUE:   hue_q   <= cfg_s.data[8:0];
          CFG_SAT:   sat_q   <= cfg_s.data;
          CFG_VAL:   val_q   <= cfg_s.data;
          CFG_GAIN:  gain_q  <= cfg_s.data;
          CFG_FLOOR: floor_q <= cfg_s.data;
          CFG_DECAY: decay_q <= cfg_s.data;
          CFG_MIX:   mix_q   <= cfg_s.data;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    dt_q      <= dt_d;
    lvl_q     <= lvl_d;
    live_q    <= live_d;
    term_q    <= term_d;
    sum_q     <= sum_d;
    f_q       <= f_d;
    n_q       <= n_d;
    k_q       <= k_d;
    u_q       <= u_d;
    u2_q      <= u2_d;
    t_q       <= t_d;
    quad_q    <= quad_d;
    div_rem_q <= div_rem_d;
    div_quo_q <= div_quo_d;
    div_den_q <= div_den_d;
    ohue_q    <= ohue_d;
    osat_q    <= osat_d;
    oval_q    <= oval_d;
    opeak_q   <= opeak_d;
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

endmodule

[rtl/phlm_checker.sv]
`timescale 1ns / 1ps
// phlm_checker: port-level checks on the peak hold level meter, bound to the top
// depends on phlm_pkg
module phlm_checker import phlm_pkg::*; #(
  parameter int LB = LEVEL_BITS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [8:0]    out_hue_i,
  input logic [LB-1:0] peak_level_i,
  input logic          cfg_valid_i,
  input logic          cfg_ready_i
);

  // a request keeps the block busy: ready stays low after it is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i ##1 !in_ready_i)
    else $error("request taken without busy period");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(peak_level_i)
      && $stable(out_hue_i)))
    else $error("stalled result changed");

  a_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_hue_i < 9'd360))
    else $error("hue out of range");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write refused");

endmodule

bind peak_hold_level_meter phlm_checker #(.LB(LEVEL_BITS)) u_phlm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_s.valid),
  .in_ready_i   (in_s.ready),
  .out_valid_i  (out_s.valid),
  .out_ready_i  (out_s.ready),
  .out_hue_i    (out_s.out_hue),
  .peak_level_i (out_s.peak_level),
  .cfg_valid_i  (cfg_s.valid),
  .cfg_ready_i  (cfg_s.ready)
);
